// File: design/medl_pkg.sv
// shared types and constants of the median-edge-detector error labeler
// no dependencies
`timescale 1ns / 1ps

package medl_pkg;

    localparam int PIX_W     = 8;
    localparam int ERR_W     = 9;
    localparam int CODE_W    = 8;
    localparam int ALPHA_W   = 4;
    localparam int RW_W      = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 4'd3;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 4'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 4'd8;
    localparam int                 ROW_RST   = 512;
    localparam int                 ROW_MIN   = 2;

    // pixel metadata carried with the line buffer read
    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic             interior;
    } t_s1;

endpackage

// File: design/medl_if.sv
// request channels of the labeler: pixel input and labeled result
// depends on medl_pkg
`timescale 1ns / 1ps

interface medl_pix_if;
    logic                         valid;
    logic                         ready;
    logic [medl_pkg::PIX_W-1:0]   pixel;
    logic                         frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface medl_lab_if;
    logic                                valid;
    logic                                ready;
    logic signed [medl_pkg::ERR_W-1:0]   labeled_value;
    logic                                label_bit;
    logic signed [medl_pkg::ERR_W-1:0]   pred_error;
    logic [medl_pkg::CODE_W-1:0]         error_code;

    modport source (output valid, labeled_value, label_bit, pred_error, error_code,
                    input ready);
    modport sink   (input valid, labeled_value, label_bit, pred_error, error_code,
                    output ready);
endinterface

// File: design/medl_ram.sv
// generic simple dual-port ram, one write and one registered read port
// read returns the old entry on a same-address write; no dependencies
`timescale 1ns / 1ps

module medl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/medl_front.sv
// configuration registers, column tracking and line buffer access
// depends on medl_pkg, medl_if
`timescale 1ns / 1ps

module medl_front #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    medl_pix_if.sink                              i_pix,
    input  logic                                  i_cfg_we,
    input  logic [medl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [medl_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                                  i_s1_ready,
    output logic                                  o_s1_valid,
    output medl_pkg::t_s1                         o_s1,
    output logic [medl_pkg::ALPHA_W-1:0]          o_alpha,
    output logic                                  o_ram_en,
    output logic [$clog2(MAX_ROW_WIDTH)-1:0]      o_ram_addr,
    output logic [medl_pkg::PIX_W-1:0]            o_ram_wdata
);

    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int NW = CW + 1;
    localparam int LW = (medl_pkg::RW_W > NW) ? medl_pkg::RW_W : NW;
    localparam int W_RST = (medl_pkg::ROW_RST > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH
                                                               : medl_pkg::ROW_RST;

    logic [medl_pkg::ALPHA_W-1:0] r_alpha, n_alpha;
    logic [NW-1:0]                r_width, n_width;
    logic [CW-1:0]                r_col, n_col;
    logic                         r_first, n_first;
    logic                         r_s1_valid;
    medl_pkg::t_s1                r_s1;

    logic                         accept;
    logic [CW-1:0]                col;
    logic                         first;
    logic [NW-1:0]                col_inc;
    logic [LW-1:0]                cfg_w;

    assign i_pix.ready = !r_s1_valid || i_s1_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    // config values are stored already clamped
    assign cfg_w = LW'(i_cfg_data);

    always_comb begin
        n_alpha = r_alpha;
        n_width = r_width;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                medl_pkg::CFG_ALPHA_BITS: begin
                    if (i_cfg_data[medl_pkg::ALPHA_W-1:0] < medl_pkg::ALPHA_MIN) begin
                        n_alpha = medl_pkg::ALPHA_MIN;
                    end else if (i_cfg_data[medl_pkg::ALPHA_W-1:0] > medl_pkg::ALPHA_MAX) begin
                        n_alpha = medl_pkg::ALPHA_MAX;
                    end else begin
                        n_alpha = i_cfg_data[medl_pkg::ALPHA_W-1:0];
                    end
                end
                medl_pkg::CFG_ROW_WIDTH: begin
                    if (cfg_w < LW'(medl_pkg::ROW_MIN)) begin
                        n_width = NW'(medl_pkg::ROW_MIN);
                    end else if (cfg_w > LW'(MAX_ROW_WIDTH)) begin
                        n_width = NW'(MAX_ROW_WIDTH);
                    end else begin
                        n_width = cfg_w[NW-1:0];
                    end
                end
                default: begin
                    n_alpha = r_alpha;
                end
            endcase
        end
    end

    // column position of the current pixel
    assign col     = i_pix.frame_start ? '0 : r_col;
    assign first   = i_pix.frame_start || r_first;
    assign col_inc = {1'b0, col} + NW'(1);

    always_comb begin
        n_col   = r_col;
        n_first = r_first;
        if (accept) begin
            if (col_inc >= r_width) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col   = col_inc[CW-1:0];
                n_first = first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= medl_pkg::ALPHA_RST;
            r_width    <= NW'(W_RST);
            r_col      <= '0;
            r_first    <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            r_alpha <= n_alpha;
            r_width <= n_width;
            r_col   <= n_col;
            r_first <= n_first;
            if (i_pix.ready) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.x        <= i_pix.pixel;
            r_s1.interior <= (col != '0) && !first;
        end
    end

    // read the upper pixel and replace it with the current one
    assign o_ram_en    = accept;
    assign o_ram_addr  = col;
    assign o_ram_wdata = i_pix.pixel;

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_alpha    = r_alpha;

endmodule

// File: design/medl_back.sv
// median prediction stage and labeling stage with the result register
// depends on medl_pkg, medl_if
`timescale 1ns / 1ps

module medl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  medl_pkg::t_s1                 i_s1,
    input  logic [medl_pkg::PIX_W-1:0]    i_upper,
    input  logic [medl_pkg::ALPHA_W-1:0]  i_alpha,
    output logic                          o_s1_ready,
    medl_lab_if.source                    o_lab
);

    localparam int PW = medl_pkg::PIX_W;
    localparam int EW = medl_pkg::ERR_W;
    localparam int KW = medl_pkg::CODE_W;
    localparam logic [medl_pkg::ALPHA_W-1:0] ALPHA_ONE = 4'd1;

    logic          r_s2_valid;
    logic          r_out_valid;
    logic [PW-1:0] r_left;
    logic [PW-1:0] r_upleft;
    logic [PW-1:0] r_s2_x;
    logic          r_s2_interior;
    logic [EW-1:0] r_s2_err;
    logic [EW-1:0] r_lab;
    logic          r_label;
    logic [EW-1:0] r_err;
    logic [KW-1:0] r_code;

    logic          en_out;
    logic          en_s2;

    logic [PW-1:0] lo, hi, v;
    logic [EW:0]   grad;
    logic [EW-1:0] n_err;

    logic [EW-1:0] half;
    logic [EW-1:0] mask9;
    logic [KW-1:0] mask;
    logic          in_rng;
    logic          lab_ok;
    logic [PW-1:0] p;
    logic [EW-1:0] n_lab;
    logic [EW-1:0] neg_err;
    logic [KW-1:0] n_code;

    assign en_out     = !r_out_valid || o_lab.ready;
    assign en_s2      = en_out || !r_s2_valid;
    assign o_s1_ready = en_s2;

    // median edge detector on left, upper and upper-left
    always_comb begin
        lo   = (r_left < i_upper) ? r_left : i_upper;
        hi   = (r_left < i_upper) ? i_upper : r_left;
        grad = (EW+1)'(r_left) + (EW+1)'(i_upper) - (EW+1)'(r_upleft);
        if (r_upleft <= lo) begin
            v = hi;
        end else if (r_upleft >= hi) begin
            v = lo;
        end else begin
            v = grad[PW-1:0];
        end
        n_err = {1'b0, i_s1.x} - {1'b0, v};
    end

    // range check, masked complement and error code
    always_comb begin
        half    = EW'(1) << (i_alpha - ALPHA_ONE);
        mask9   = (EW'(1) << i_alpha) - EW'(1);
        mask    = mask9[KW-1:0];
        in_rng  = ($signed(r_s2_err) >= -$signed(half))
               && ($signed(r_s2_err) <= $signed(half - EW'(1)));
        lab_ok  = r_s2_interior && in_rng;
        p       = (r_s2_x != '0) ? ~(r_s2_x - PW'(1)) : '0;
        n_lab   = {1'b0, p & ~mask} + r_s2_err;
        neg_err = EW'(0) - r_s2_err;
        n_code  = (r_s2_err[EW-1] ? r_s2_err[KW-1:0] : neg_err[KW-1:0]) & mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_upleft    <= '0;
        end else begin
            if (en_s2) begin
                r_s2_valid <= i_s1_valid;
                if (i_s1_valid) begin
                    r_left   <= i_s1.x;
                    r_upleft <= i_upper;
                end
            end
            if (en_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2 && i_s1_valid) begin
            r_s2_x        <= i_s1.x;
            r_s2_interior <= i_s1.interior;
            r_s2_err      <= n_err;
        end
        if (en_out && r_s2_valid) begin
            r_lab   <= lab_ok ? n_lab : {1'b0, r_s2_x};
            r_label <= !lab_ok;
            r_err   <= r_s2_interior ? r_s2_err : '0;
            r_code  <= lab_ok ? n_code : '0;
        end
    end

    assign o_lab.valid         = r_out_valid;
    assign o_lab.labeled_value = $signed(r_lab);
    assign o_lab.label_bit     = r_label;
    assign o_lab.pred_error    = $signed(r_err);
    assign o_lab.error_code    = r_code;

endmodule

// File: design/med_predict_error_labeler.sv
// top level of the median-edge-detector prediction error labeler
// depends on medl_pkg, medl_if, medl_ram, medl_front, medl_back
`timescale 1ns / 1ps

// Takes one 8-bit pixel per clock in raster order while results are taken
// and returns one labeled result per pixel, in order. Sustained rate is one
// pixel per cycle while the output is not stalled; each result passes
// through three register stages: the line buffer read at the accepting edge,
// the median prediction, and labeling into the output register. The previous
// row lives in a MAX_ROW_WIDTH x 8 dual-port RAM that is read and rewritten
// at the same column in the accept cycle, so no forwarding is needed and no
// clearing pass runs after reset. The first row of every frame and the first
// pixel of every row pass through with label 1. alpha_bits and row_width are
// clamped when written and must only be changed while the block is idle.

module med_predict_error_labeler #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    medl_pix_if.sink                        i_pix,
    medl_lab_if.source                      o_lab,
    input  logic                            i_cfg_we,
    input  logic [medl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [medl_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_ROW_WIDTH);

    logic                         s1_valid;
    logic                         s1_ready;
    medl_pkg::t_s1                s1;
    logic [medl_pkg::ALPHA_W-1:0] alpha;
    logic                         ram_en;
    logic [AW-1:0]                ram_addr;
    logic [medl_pkg::PIX_W-1:0]   ram_wdata;
    logic [medl_pkg::PIX_W-1:0]   ram_rdata;

    medl_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s1_ready  (s1_ready),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_alpha     (alpha),
        .o_ram_en    (ram_en),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata)
    );

    medl_ram #(
        .WIDTH (medl_pkg::PIX_W),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_en),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_en),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    medl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_upper    (ram_rdata),
        .i_alpha    (alpha),
        .o_s1_ready (s1_ready),
        .o_lab      (o_lab)
    );

endmodule
